[rtl/core/lccc_pkg.sv]
`default_nettype none
package lccc_pkg;

  localparam int PRICE_W = 24;
  localparam int BASE_W  = 25;
  localparam int SCALE_W = 10;
  localparam int PX_W    = 8;
  localparam int COL_W   = 6;
  localparam int FUNC_W  = 2;
  localparam int CIDX_W  = 2;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_PUSH   = 2'd0;
  localparam func_t FUNC_REDRAW = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  typedef logic [CIDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_SCALE      = 2'd0;
  localparam reg_idx_t REG_START_BASE = 2'd1;

  localparam int PX_CENTER     = 128;
  localparam int PX_MIN        = 10;
  localparam int PX_MAX        = 240;
  localparam int DRIFT_PX      = 10;
  localparam int ROUND_HALF    = 25;
  localparam int MIN_CANDLE_PX = 4;
  localparam int SCALE_RESET   = 5;

  // floor(x / 50) = ((x >> 1) * RND_MULT) >> RND_SHIFT for x below 2^25
  localparam int          RND_SHIFT = 29;
  localparam logic [24:0] RND_MULT  = 25'd21474837;

  // Per-column work steps: two averages, then six pixel rows
  typedef logic [2:0] step_t;
  localparam step_t STEP_SAVG  = 3'd0;
  localparam step_t STEP_LAVG  = 3'd1;
  localparam step_t STEP_OPEN  = 3'd2;
  localparam step_t STEP_HIGH  = 3'd3;
  localparam step_t STEP_LOW   = 3'd4;
  localparam step_t STEP_CLOSE = 3'd5;
  localparam step_t STEP_SROW  = 3'd6;
  localparam step_t STEP_LROW  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RND_MUL,
    ST_RND_FIN,
    ST_PUSH_WR,
    ST_RD_S,
    ST_RD_L,
    ST_RD_C,
    ST_CAP,
    ST_SETUP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/lccc_if.sv]
`default_nettype none
interface lccc_cmd_if import lccc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [PRICE_W-1:0] open_cents;
  logic [PRICE_W-1:0] high_cents;
  logic [PRICE_W-1:0] low_cents;
  logic [PRICE_W-1:0] close_cents;
  logic [PRICE_W-1:0] live_price_cents;

  modport source(output valid, func, open_cents, high_cents, low_cents, close_cents,
                 live_price_cents, input ready);
  modport sink(input valid, func, open_cents, high_cents, low_cents, close_cents,
               live_price_cents, output ready);
endinterface

interface lccc_col_if import lccc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [COL_W-1:0]         column;
  logic [PX_W-1:0]          high_px;
  logic [PX_W-1:0]          low_px;
  logic [PX_W-1:0]          open_px;
  logic [PX_W-1:0]          close_px;
  logic [PX_W-1:0]          short_avg_px;
  logic [PX_W-1:0]          long_avg_px;
  logic signed [BASE_W-1:0] base_out_cents;
  logic                     last;

  modport source(output valid, column, high_px, low_px, open_px, close_px, short_avg_px,
                 long_avg_px, base_out_cents, last, input ready);
  modport sink(input valid, column, high_px, low_px, open_px, close_px, short_avg_px,
               long_avg_px, base_out_cents, last, output ready);
endinterface

interface lccc_cfg_if import lccc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [BASE_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/live_candle_chart_columns_core.sv]
`default_nettype none
// Channel  Role  Payload
// cmd      sink  func, open/high/low/close_cents, live_price_cents
// col      src   column, high/low/open/close_px, short/long_avg_px, base_out_cents, last
// cfg      sink  index (0 cents_per_pixel, 1 start_base_cents), data
//
// Every push, redraw or clear gives CHART_WIDTH columns, oldest first.
// A stored column passes states RD_S, RD_L, RD_C, CAP and EMIT (three history memory reads).
// A computed column may use the shared shift-subtract divider: a PRICE_W-bit quotient per
// average, a PX_W-bit quotient per pixel row. Push computes only the newest column, redraw
// each stored one, clear none. Reset empties the history at once through per-entry valid
// flags. A stall on col holds the sequencer; cmd is taken only between runs.
module live_candle_chart_columns_core import lccc_pkg::*; #(
  parameter int CHART_WIDTH  = 60,
  parameter int SHORT_WINDOW = 10,
  parameter int LONG_WINDOW  = 20
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lccc_cmd_if.sink    cmd,
  lccc_col_if.source  col,
  lccc_cfg_if.sink    cfg
);

  localparam int AW     = $clog2(CHART_WIDTH);
  localparam int MAXWIN = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
  localparam int CW     = $clog2(MAXWIN + 1);
  localparam int DVW    = PRICE_W + CW;
  localparam logic [AW-1:0] LAST_POS = AW'(CHART_WIDTH - 1);
  localparam logic [AW:0]   WIDTH_V  = (AW+1)'(CHART_WIDTH);

  function automatic logic [AW-1:0] phys(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= WIDTH_V) ? s - WIDTH_V : s;
    return t[AW-1:0];
  endfunction

  function automatic logic [PX_W-1:0] row_of(input logic [PX_W-1:0] q, input logic neg);
    logic signed [PX_W+1:0] r;
    r = neg ? ($signed((PX_W+2)'(PX_CENTER)) - $signed({2'b00, q}))
            : ($signed((PX_W+2)'(PX_CENTER)) + $signed({2'b00, q}));
    if (r < $signed((PX_W+2)'(PX_MIN))) r = (PX_W+2)'(PX_MIN);
    if (r > $signed((PX_W+2)'(PX_MAX))) r = (PX_W+2)'(PX_MAX);
    return r[PX_W-1:0];
  endfunction

  state_t state, state_next;

  // configuration and chart base
  logic [SCALE_W-1:0]     scale;
  logic [SCALE_W-1:0]     scale_eff;
  logic signed [BASE_W:0] base;
  logic signed [BASE_W:0] run_base;

  // captured command
  func_t              func_r;
  logic [PRICE_W-1:0] cand_o, cand_h, cand_l, cand_c, rnd_src;

  // storage
  logic [4*PRICE_W-1:0] hist_mem [CHART_WIDTH];
  logic [6*PX_W-1:0]    pix_mem  [CHART_WIDTH];
  logic [CHART_WIDTH-1:0] vld;
  logic [4*PRICE_W-1:0] rd_hist;
  logic [6*PX_W-1:0]    rd_pix;
  logic                 rd_vld;
  logic [AW-1:0]        rd_addr, cur_addr;
  logic [AW-1:0]        head, pos;
  logic                 hist_we, pix_we;

  // sliding sums
  logic [DVW-1:0] sum_s, sum_l;
  logic [CW-1:0]  cnt_s, cnt_l;
  logic           s_ok, l_ok;
  logic [AW-1:0]  pos_s, pos_l;

  // current column
  logic [PRICE_W-1:0] cur_o, cur_h, cur_l, cur_c, avg_s, avg_l;
  logic [PRICE_W-1:0] cap_c;
  logic               cap_comp;
  logic [PX_W-1:0]    px [6];
  logic [6*PX_W-1:0]  col_pix, fin_pix;
  step_t              step;

  // divider
  logic [DVW-1:0]     div_rem, div_dsh;
  logic [PRICE_W-1:0] div_q, q_new;
  logic [4:0]         div_cnt;
  logic               div_neg, div_ge;

  // round to step
  logic [48:0]          rnd_prod;
  logic [24:0]          rnd_x;
  logic [19:0]          rnd_q;
  logic signed [BASE_W:0] rnd_val;

  // rebase check
  logic signed [BASE_W+1:0] drift_d;
  logic [BASE_W:0]          drift_mag;
  logic [SCALE_W+3:0]       drift_thr;
  logic                     rebase;
  logic signed [BASE_W:0]   base_new;

  // row setup
  logic [PRICE_W-1:0]       stp_price;
  logic signed [BASE_W+1:0] row_d;
  logic [BASE_W-1:0]        row_mag;
  logic                     row_neg, row_sat, setup_skip;
  logic [PRICE_W-1:0]       setup_res, res_val;
  logic                     res_we;

  // widening
  logic [PX_W-1:0] fin_op, fin_cp, body;

  // output register
  logic               out_valid, out_free, out_last;
  logic [COL_W-1:0]   out_column;
  logic [6*PX_W-1:0]  out_pix;
  logic [BASE_W-1:0]  out_base;

  assign scale_eff = (scale == '0) ? SCALE_W'(1) : scale;
  assign out_free  = !out_valid || col.ready;
  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign col.valid          = out_valid;
  assign col.column         = out_column;
  assign col.high_px        = out_pix[6*PX_W-1:5*PX_W];
  assign col.low_px         = out_pix[5*PX_W-1:4*PX_W];
  assign col.open_px        = out_pix[4*PX_W-1:3*PX_W];
  assign col.close_px       = out_pix[3*PX_W-1:2*PX_W];
  assign col.short_avg_px   = out_pix[2*PX_W-1:PX_W];
  assign col.long_avg_px    = out_pix[PX_W-1:0];
  assign col.base_out_cents = $signed(out_base);
  assign col.last           = out_last;

  // rounding and rebase
  assign rnd_x     = {1'b0, rnd_src} + 25'(ROUND_HALF);
  assign rnd_q     = rnd_prod[48:RND_SHIFT];
  assign rnd_val   = $signed(26'({rnd_q, 5'b0}) + 26'({rnd_q, 4'b0}) + 26'({rnd_q, 1'b0}));
  assign drift_d   = $signed({3'b000, cand_c}) - $signed({base[BASE_W], base});
  assign drift_mag = drift_d[BASE_W+1] ? 26'(-drift_d) : drift_d[BASE_W:0];
  assign drift_thr = (SCALE_W+4)'({scale_eff, 3'b000}) + (SCALE_W+4)'({scale_eff, 1'b0});
  assign rebase    = !base[BASE_W] && (base != '0) && ((BASE_W+1)'(drift_thr) < drift_mag);
  assign base_new  = rebase ? rnd_val : base;

  // window bookkeeping
  assign s_ok  = 32'(pos) >= 32'(SHORT_WINDOW);
  assign l_ok  = 32'(pos) >= 32'(LONG_WINDOW);
  assign pos_s = s_ok ? AW'(32'(pos) - 32'(SHORT_WINDOW)) : '0;
  assign pos_l = l_ok ? AW'(32'(pos) - 32'(LONG_WINDOW)) : '0;
  assign cur_addr = phys({1'b0, head} + {1'b0, pos});
  assign cap_c    = rd_vld ? rd_hist[PRICE_W-1:0] : '0;
  assign cap_comp = ((func_r == FUNC_PUSH) && (pos == LAST_POS)) ||
                    ((func_r == FUNC_REDRAW) && (cap_c != '0));

  always_comb begin
    case (state)
      ST_RD_S: rd_addr = phys({1'b0, head} + {1'b0, pos_s});
      ST_RD_L: rd_addr = phys({1'b0, head} + {1'b0, pos_l});
      default: rd_addr = cur_addr;
    endcase
  end

  assign hist_we = (state == ST_PUSH_WR);
  assign pix_we  = (state == ST_FIN) && (func_r == FUNC_PUSH);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[head] <= {cand_o, cand_h, cand_l, cand_c};
    if (pix_we) pix_mem[cur_addr] <= fin_pix;
    rd_hist <= hist_mem[rd_addr];
    rd_pix  <= pix_mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  // step setup: skip the divider where the answer is known
  always_comb begin
    case (step)
      STEP_OPEN:  stp_price = cur_o;
      STEP_HIGH:  stp_price = cur_h;
      STEP_LOW:   stp_price = cur_l;
      STEP_CLOSE: stp_price = cur_c;
      STEP_SROW:  stp_price = avg_s;
      default:    stp_price = avg_l;
    endcase
    row_d   = $signed({3'b000, stp_price}) - $signed({run_base[BASE_W], run_base});
    row_neg = row_d[BASE_W+1];
    row_mag = row_neg ? BASE_W'(-row_d) : row_d[BASE_W-1:0];
    row_sat = (27'(row_mag) >= 27'({scale_eff, 8'b0}));
    case (step)
      STEP_SAVG: begin
        setup_skip = (cnt_s == '0);
        setup_res  = '0;
      end
      STEP_LAVG: begin
        setup_skip = (cnt_l == '0);
        setup_res  = '0;
      end
      default: begin
        setup_skip = run_base[BASE_W] || row_sat;
        if (run_base[BASE_W]) setup_res = PRICE_W'(PX_CENTER);
        else setup_res = row_neg ? PRICE_W'(PX_MIN) : PRICE_W'(PX_MAX);
      end
    endcase
  end

  assign div_ge = (div_rem >= div_dsh);
  assign q_new  = {div_q[PRICE_W-2:0], div_ge};

  always_comb begin
    res_we  = 1'b0;
    res_val = setup_res;
    if ((state == ST_SETUP) && setup_skip) begin
      res_we = 1'b1;
    end else if ((state == ST_DIV) && (div_cnt == 5'd1)) begin
      res_we  = 1'b1;
      res_val = (step == STEP_SAVG || step == STEP_LAVG) ? q_new
              : PRICE_W'(row_of(q_new[PX_W-1:0], div_neg));
    end
  end

  // minimum body widening
  always_comb begin
    fin_op = px[0];
    fin_cp = px[3];
    body   = (px[0] > px[3]) ? px[0] - px[3] : px[3] - px[0];
    if (body < PX_W'(MIN_CANDLE_PX)) begin
      if (cur_o > cur_c) begin
        fin_op = px[0] - PX_W'(MIN_CANDLE_PX / 2);
        fin_cp = px[3] + PX_W'(MIN_CANDLE_PX / 2);
      end else begin
        fin_cp = px[3] - PX_W'(MIN_CANDLE_PX / 2);
        fin_op = px[0] + PX_W'(MIN_CANDLE_PX / 2);
      end
    end
    fin_pix = {px[1], px[2], fin_op, fin_cp, px[4], px[5]};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.func)
            FUNC_PUSH, FUNC_REDRAW: state_next = ST_RND_MUL;
            FUNC_CLEAR:             state_next = ST_EMIT;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_RND_MUL: state_next = ST_RND_FIN;
      ST_RND_FIN: state_next = (func_r == FUNC_PUSH) ? ST_PUSH_WR : ST_RD_S;
      ST_PUSH_WR: state_next = ST_RD_S;
      ST_RD_S:    state_next = ST_RD_L;
      ST_RD_L:    state_next = ST_RD_C;
      ST_RD_C:    state_next = ST_CAP;
      ST_CAP:     state_next = cap_comp ? ST_SETUP : ST_EMIT;
      ST_SETUP: begin
        if (!setup_skip) state_next = ST_DIV;
        else if (step == STEP_LROW) state_next = ST_FIN;
      end
      ST_DIV: begin
        if (div_cnt == 5'd1) state_next = (step == STEP_LROW) ? ST_FIN : ST_SETUP;
      end
      ST_FIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (pos == LAST_POS) state_next = ST_IDLE;
          else state_next = (func_r == FUNC_CLEAR) ? ST_EMIT : ST_RD_S;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_W'(SCALE_RESET);
      base      <= '1;
      vld       <= '0;
      head      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_SCALE:      scale <= cfg.data[SCALE_W-1:0];
          REG_START_BASE: base  <= $signed({cfg.data[BASE_W-1], cfg.data});
          default: ;
        endcase
      end
      if (col.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          pos <= '0;
          if (cmd.valid && cmd.func == FUNC_CLEAR) vld <= '0;
        end
        ST_RND_FIN: if (func_r == FUNC_PUSH) base <= base_new;
        ST_PUSH_WR: begin
          vld[head] <= 1'b1;
          head      <= (head == LAST_POS) ? '0 : head + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pos != LAST_POS) pos <= pos + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func_r   <= cmd.func;
        cand_o   <= cmd.open_cents;
        cand_h   <= cmd.high_cents;
        cand_l   <= cmd.low_cents;
        cand_c   <= cmd.close_cents;
        rnd_src  <= (cmd.func == FUNC_PUSH) ? cmd.close_cents : cmd.live_price_cents;
        run_base <= base;
        col_pix  <= '0;
        sum_s    <= '0;
        sum_l    <= '0;
        cnt_s    <= '0;
        cnt_l    <= '0;
      end
      ST_RND_MUL: rnd_prod <= 49'(rnd_x[24:1]) * 49'(RND_MULT);
      ST_RND_FIN: begin
        if (func_r == FUNC_PUSH) run_base <= base_new;
        else if (rnd_src != '0) run_base <= rnd_val;
      end
      ST_RD_L: begin
        if (s_ok && rd_vld && rd_hist[PRICE_W-1:0] != '0) begin
          sum_s <= sum_s - DVW'(rd_hist[PRICE_W-1:0]);
          cnt_s <= cnt_s - 1'b1;
        end
      end
      ST_RD_C: begin
        if (l_ok && rd_vld && rd_hist[PRICE_W-1:0] != '0) begin
          sum_l <= sum_l - DVW'(rd_hist[PRICE_W-1:0]);
          cnt_l <= cnt_l - 1'b1;
        end
      end
      ST_CAP: begin
        cur_o <= rd_vld ? rd_hist[4*PRICE_W-1:3*PRICE_W] : '0;
        cur_h <= rd_vld ? rd_hist[3*PRICE_W-1:2*PRICE_W] : '0;
        cur_l <= rd_vld ? rd_hist[2*PRICE_W-1:PRICE_W] : '0;
        cur_c <= cap_c;
        if (cap_c != '0) begin
          sum_s <= sum_s + DVW'(cap_c);
          sum_l <= sum_l + DVW'(cap_c);
          cnt_s <= cnt_s + 1'b1;
          cnt_l <= cnt_l + 1'b1;
        end
        step <= STEP_SAVG;
        // redraw shows empty columns as zero; push replays stored pixels
        col_pix <= (func_r == FUNC_PUSH && rd_vld) ? rd_pix : '0;
      end
      ST_SETUP: begin
        div_q <= '0;
        case (step)
          STEP_SAVG: begin
            div_rem <= sum_s;
            div_dsh <= DVW'({cnt_s, {(PRICE_W-1){1'b0}}});
            div_cnt <= 5'(PRICE_W);
          end
          STEP_LAVG: begin
            div_rem <= sum_l;
            div_dsh <= DVW'({cnt_l, {(PRICE_W-1){1'b0}}});
            div_cnt <= 5'(PRICE_W);
          end
          default: begin
            div_rem <= DVW'(row_mag);
            div_dsh <= DVW'({scale_eff, 7'b0});
            div_cnt <= 5'(PX_W);
            div_neg <= row_neg;
          end
        endcase
      end
      ST_DIV: begin
        div_q   <= q_new;
        div_rem <= div_ge ? div_rem - div_dsh : div_rem;
        div_dsh <= div_dsh >> 1;
        div_cnt <= div_cnt - 1'b1;
      end
      ST_FIN: col_pix <= fin_pix;
      ST_EMIT: begin
        if (out_free) begin
          out_column <= COL_W'(pos);
          out_pix    <= col_pix;
          out_base   <= run_base[BASE_W-1:0];
          out_last   <= (pos == LAST_POS);
        end
      end
      default: ;
    endcase
    if (res_we) begin
      case (step)
        STEP_SAVG: avg_s <= res_val;
        STEP_LAVG: avg_l <= res_val;
        default:   px[3'(step - STEP_OPEN)] <= res_val[PX_W-1:0];
      endcase
      step <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire
